>>> design/tdc_pkg.sv
// Package: widths, store geometry and shared types for the distortion colour block
`timescale 1ns / 1ps
package tdc_pkg;
    localparam int VertexCount = 4096;
    localparam int IdxW        = 12;
    localparam int CoordW      = 24;
    localparam int ColorW      = 16;
    localparam int GainW       = 16;
    localparam int MuW         = 58;
    localparam int NumW        = 100;
    localparam int DivSteps    = NumW + 32;

    typedef enum logic {
        t_OP_VERTEX = 1'b0,
        t_OP_FACE   = 1'b1
    } t_op;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic signed [CoordW-1:0] u;
        logic signed [CoordW-1:0] v;
    } t_vertex;

    typedef struct packed {
        logic [ColorW-1:0] red;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] blue;
        logic              degenerate;
    } t_color;
endpackage

>>> design/triangle_distortion_color.sv
// Top level: triangle distortion colouring pipeline
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  input   | in        | i_valid / o_stall  | operation, vertex_index, pos, tex, corners
//  result  | out       | o_valid / i_stall  | face_red/green/blue, degenerate
//  config  | in        | i_cfg_valid / o_cfg_ready | distortion_gain
//
// One request enters per cycle unless the output stall holds the pipe. A face passes
// store read, edge vectors, Gram products, determinants, two bit-per-stage
// dividers, a bit-per-stage square root and the colour stage on its way to
// o_valid: 7 front stages, 132 divider stages, 2 discriminant stages, 58 root
// stages and 3 colour stages. Reset clears all valid bits and loads gain 0.5.
// A stall freezes every stage at once; the last stage is the output register.
`timescale 1ns / 1ps
module triangle_distortion_color (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [11:0]                   i_vertex_index,
    input  logic signed [23:0]            i_pos_x,
    input  logic signed [23:0]            i_pos_y,
    input  logic signed [23:0]            i_pos_z,
    input  logic signed [23:0]            i_tex_u,
    input  logic signed [23:0]            i_tex_v,
    input  logic [11:0]                   i_corner_a,
    input  logic [11:0]                   i_corner_b,
    input  logic [11:0]                   i_corner_c,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [15:0]                   o_face_red,
    output logic [15:0]                   o_face_green,
    output logic [15:0]                   o_face_blue,
    output logic                          o_degenerate,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [15:0]                   i_cfg_data
);
    localparam int DivLat  = tdc_pkg::DivSteps;
    localparam int SqLat   = tdc_pkg::MuW;
    localparam int NW      = tdc_pkg::NumW;
    localparam int MW      = tdc_pkg::MuW;

    // Whole pipe advances when the output register is free or empty.
    logic w_adv;
    logic r_vout;
    assign w_adv   = !(r_vout && i_stall);
    assign o_stall = !w_adv;
    assign o_cfg_ready = 1'b1;

    logic [15:0] r_gain;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 16'd32768;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    // Stage 0: store read. Vertex writes hit all three replicas.
    logic w_acc, w_face, w_wr;
    assign w_acc  = i_valid && w_adv;
    assign w_face = w_acc && (i_operation == tdc_pkg::t_OP_FACE);
    assign w_wr   = w_acc && (i_operation == tdc_pkg::t_OP_VERTEX);

    tdc_pkg::t_vertex w_wv, w_va, w_vb, w_vc;
    assign w_wv = '{x: i_pos_x, y: i_pos_y, z: i_pos_z, u: i_tex_u, v: i_tex_v};

    tdc_vstore u_sa (.i_clk, .i_we(w_wr), .i_waddr(i_vertex_index), .i_wdata(w_wv),
                     .i_re(w_adv), .i_raddr(i_corner_a), .o_rdata(w_va));
    tdc_vstore u_sb (.i_clk, .i_we(w_wr), .i_waddr(i_vertex_index), .i_wdata(w_wv),
                     .i_re(w_adv), .i_raddr(i_corner_b), .o_rdata(w_vb));
    tdc_vstore u_sc (.i_clk, .i_we(w_wr), .i_waddr(i_vertex_index), .i_wdata(w_wv),
                     .i_re(w_adv), .i_raddr(i_corner_c), .o_rdata(w_vc));

    logic r_v1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_adv) r_v1 <= w_face;
    end

    // Stage 1: edge vectors (25 bit signed).
    logic signed [24:0] r_e1 [3], r_e2 [3], r_f1 [2], r_f2 [2];
    logic r_v2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_adv) r_v2 <= r_v1;
        if (w_adv) begin
            r_e1[0] <= 25'(w_vb.x) - 25'(w_va.x);
            r_e1[1] <= 25'(w_vb.y) - 25'(w_va.y);
            r_e1[2] <= 25'(w_vb.z) - 25'(w_va.z);
            r_e2[0] <= 25'(w_vc.x) - 25'(w_va.x);
            r_e2[1] <= 25'(w_vc.y) - 25'(w_va.y);
            r_e2[2] <= 25'(w_vc.z) - 25'(w_va.z);
            r_f1[0] <= 25'(w_vb.u) - 25'(w_va.u);
            r_f1[1] <= 25'(w_vb.v) - 25'(w_va.v);
            r_f2[0] <= 25'(w_vc.u) - 25'(w_va.u);
            r_f2[1] <= 25'(w_vc.v) - 25'(w_va.v);
        end
    end

    // Stage 2: elementwise products.
    logic signed [49:0] r_pg [9], r_ph [6];
    logic r_v3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_adv) r_v3 <= r_v2;
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_pg[k]   <= r_e1[k] * r_e1[k];
                r_pg[k+3] <= r_e2[k] * r_e2[k];
                r_pg[k+6] <= r_e1[k] * r_e2[k];
            end
            for (int k = 0; k < 2; k++) begin
                r_ph[k]   <= r_f1[k] * r_f1[k];
                r_ph[k+2] <= r_f2[k] * r_f2[k];
                r_ph[k+4] <= r_f1[k] * r_f2[k];
            end
        end
    end

    // Stage 3: Gram entries.
    logic [51:0] r_g00, r_g11, r_h00, r_h11;
    logic signed [51:0] r_g01, r_h01;
    logic r_v4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (w_adv) r_v4 <= r_v3;
        if (w_adv) begin
            r_g00 <= 52'(r_pg[0]) + 52'(r_pg[1]) + 52'(r_pg[2]);
            r_g11 <= 52'(r_pg[3]) + 52'(r_pg[4]) + 52'(r_pg[5]);
            r_g01 <= 52'(r_pg[6]) + 52'(r_pg[7]) + 52'(r_pg[8]);
            r_h00 <= 52'(r_ph[0]) + 52'(r_ph[1]);
            r_h11 <= 52'(r_ph[2]) + 52'(r_ph[3]);
            r_h01 <= 52'(r_ph[4]) + 52'(r_ph[5]);
        end
    end

    // Stage 4: magnitudes of the cross terms.
    logic [51:0] r_g00_s5, r_g11_s5, r_h00_s5, r_h11_s5, r_mg_s5, r_mh_s5;
    logic r_opp_s5, r_v5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (w_adv) r_v5 <= r_v4;
        if (w_adv) begin
            r_g00_s5 <= r_g00; r_g11_s5 <= r_g11; r_h00_s5 <= r_h00; r_h11_s5 <= r_h11;
            r_mg_s5  <= r_g01[51] ? 52'(-r_g01) : 52'(r_g01);
            r_mh_s5  <= r_h01[51] ? 52'(-r_h01) : 52'(r_h01);
            r_opp_s5 <= r_g01[51] != r_h01[51];
        end
    end

    // Stage 5: wide products, split over 26-bit halves.
    function automatic logic [103:0] f_mul52(input logic [51:0] a, input logic [51:0] b);
        logic [51:0] ll, lh, hl, hh;
        ll = 26'(a) * 26'(b);
        lh = 26'(a) * b[51:26];
        hl = a[51:26] * 26'(b);
        hh = a[51:26] * b[51:26];
        return 104'(ll) + (104'(lh) << 26) + (104'(hl) << 26) + (104'(hh) << 52);
    endfunction

    logic [103:0] r_gg, r_gx, r_hh, r_hx, r_n1, r_n2, r_cx;
    logic r_opp_s6, r_v6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else if (w_adv) r_v6 <= r_v5;
        if (w_adv) begin
            r_gg <= f_mul52(r_g00_s5, r_g11_s5);
            r_gx <= f_mul52(r_mg_s5, r_mg_s5);
            r_hh <= f_mul52(r_h00_s5, r_h11_s5);
            r_hx <= f_mul52(r_mh_s5, r_mh_s5);
            r_n1 <= f_mul52(r_g11_s5, r_h00_s5);
            r_n2 <= f_mul52(r_g00_s5, r_h11_s5);
            r_cx <= f_mul52(r_mg_s5, r_mh_s5);
            r_opp_s6 <= r_opp_s5;
        end
    end

    // Stage 6: determinants and trace numerator.
    logic [NW-1:0] r_detg, r_deth, r_num;
    logic r_v7;
    logic [104:0] w_ns, w_c2;
    assign w_ns = 105'(r_n1) + 105'(r_n2);
    assign w_c2 = {r_cx, 1'b0};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else if (w_adv) r_v7 <= r_v6;
        if (w_adv) begin
            r_detg <= NW'(r_gg - r_gx);
            r_deth <= NW'(r_hh - r_hx);
            if (r_opp_s6) r_num <= NW'(w_ns + w_c2);
            else if (w_ns >= w_c2) r_num <= NW'(w_ns - w_c2);
            else r_num <= '0;
        end
    end

    // Dividers; a zero det(G) gives a garbage quotient that the flag overrides.
    logic [MW-1:0] w_qa, w_qb;
    tdc_divider u_div_a (.i_clk, .i_en(w_adv), .i_num(r_num), .i_den(r_detg), .o_quo(w_qa));
    tdc_divider u_div_b (.i_clk, .i_en(w_adv), .i_num(r_deth), .i_den(r_detg), .o_quo(w_qb));

    logic [DivLat-1:0] r_dv, r_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= '0;
        else if (w_adv) r_dv <= {r_dv[DivLat-2:0], r_v7};
        if (w_adv) r_dz <= {r_dz[DivLat-2:0], r_detg == '0};
    end

    // Discriminant: square then subtract.
    logic [2*MW-1:0] r_aa;
    logic [MW-1:0]   r_a8, r_b8;
    logic            r_v8, r_z8;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v8 <= 1'b0;
        else if (w_adv) r_v8 <= r_dv[DivLat-1];
        if (w_adv) begin
            r_aa <= ((2*MW)'(f_mul52(52'(w_qa >> 6), 52'(w_qa >> 6))) << 12)
                  + ((2*MW)'(w_qa[5:0]) * (2*MW)'(w_qa) << 1)
                  - (2*MW)'(w_qa[5:0]) * (2*MW)'(w_qa[5:0]);
            r_a8 <= w_qa;
            r_b8 <= w_qb;
            r_z8 <= r_dz[DivLat-1];
        end
    end

    logic [2*MW-1:0] r_disc, w_fb;
    logic [MW-1:0]   r_a9;
    logic            r_v9, r_z9;
    assign w_fb = (2*MW)'(r_b8) << 34;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v9 <= 1'b0;
        else if (w_adv) r_v9 <= r_v8;
        if (w_adv) begin
            r_disc <= (r_aa >= w_fb) ? r_aa - w_fb : '0;
            r_a9 <= r_a8;
            r_z9 <= r_z8;
        end
    end

    logic [MW-1:0] w_s2;
    tdc_sqrt u_sqrt (.i_clk, .i_en(w_adv), .i_val(r_disc), .o_root(w_s2));

    logic [SqLat-1:0] r_sv, r_sz;
    logic [MW-1:0]    r_sa [SqLat];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv <= '0;
        else if (w_adv) r_sv <= {r_sv[SqLat-2:0], r_v9};
        if (w_adv) begin
            r_sz <= {r_sz[SqLat-2:0], r_z9};
            r_sa[0] <= r_a9;
            for (int k = 1; k < SqLat; k++) r_sa[k] <= r_sa[k-1];
        end
    end

    // Eigenvalues and colour terms.
    logic [MW-1:0] w_a, w_s, w_mx, w_mn;
    logic [MW:0]   w_sum;
    assign w_a   = r_sa[SqLat-1];
    assign w_s   = (w_s2 > w_a) ? w_a : w_s2;
    assign w_sum = (MW+1)'(w_a) + (MW+1)'(w_s);
    assign w_mx  = w_sum[MW:1];
    assign w_mn  = (w_a - w_s) >> 1;

    localparam logic [MW-1:0] Unit32 = MW'(1) << 32;
    logic [MW-1:0] r_rt, r_bt;
    logic r_v10, r_z10;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v10 <= 1'b0;
        else if (w_adv) r_v10 <= r_sv[SqLat-1];
        if (w_adv) begin
            r_rt <= (w_mx > Unit32) ? w_mx - Unit32 : '0;
            r_bt <= (w_mn < Unit32) ? Unit32 - w_mn : '0;
            r_z10 <= r_sz[SqLat-1];
        end
    end

    logic [MW-1:0] w_gt;
    assign w_gt = (r_rt > r_bt) ? r_rt : r_bt;

    // Product stage: t*gain (58x16), registered.
    logic [73:0] r_pr, r_pg2, r_pb;
    logic r_v11, r_z11, r_g0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v11 <= 1'b0;
        else if (w_adv) r_v11 <= r_v10;
        if (w_adv) begin
            r_pr  <= 74'(r_rt) * 74'(r_gain);
            r_pg2 <= 74'(w_gt) * 74'(r_gain);
            r_pb  <= 74'(r_bt) * 74'(r_gain);
            r_z11 <= r_z10;
            r_g0  <= r_gain == '0;
        end
    end

    function automatic logic [15:0] f_fin(input logic [73:0] p, input logic gz);
        logic [48:0] c;
        c = (49'(1) << 48) - 49'(p);
        if (gz) return 16'hFFFF;
        if (p >= (74'(1) << 48)) return '0;
        return c[48] ? 16'hFFFF : c[47:32];
    endfunction

    tdc_pkg::t_color r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vout <= 1'b0;
        else if (w_adv) r_vout <= r_v11;
        if (w_adv) begin
            if (r_z11) begin
                r_out <= '{red: '1, green: '1, blue: '1, degenerate: 1'b1};
            end else begin
                r_out <= '{red: f_fin(r_pr, r_g0), green: f_fin(r_pg2, r_g0),
                           blue: f_fin(r_pb, r_g0), degenerate: 1'b0};
            end
        end
    end

    assign o_valid      = r_vout;
    assign o_face_red   = r_out.red;
    assign o_face_green = r_out.green;
    assign o_face_blue  = r_out.blue;
    assign o_degenerate = r_out.degenerate;

`ifndef ASSERT_OFF
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_out))
        else $error("result changed under stall");
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall not tied to output backpressure");
    a_degen_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_face_red == '1 && o_face_blue == '1)
        else $error("degenerate face not white");
    a_vtx_noresult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> !r_v1)
        else $error("vertex write produced a face slot");
`endif
endmodule

>>> design/tdc_vstore.sv
// Vertex store: one replica of the vertex attributes per face corner
`timescale 1ns / 1ps
module tdc_vstore (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [tdc_pkg::IdxW-1:0]    i_waddr,
    input  tdc_pkg::t_vertex            i_wdata,
    input  logic                        i_re,
    input  logic [tdc_pkg::IdxW-1:0]    i_raddr,
    output tdc_pkg::t_vertex            o_rdata
);
    tdc_pkg::t_vertex r_mem [tdc_pkg::VertexCount];
    tdc_pkg::t_vertex r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd;
endmodule

>>> design/tdc_divider.sv
// Pipelined restoring divider: floor(n * 2^32 / d) saturated, one quotient bit per stage
`timescale 1ns / 1ps
module tdc_divider (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tdc_pkg::NumW-1:0]    i_num,
    input  logic [tdc_pkg::NumW-1:0]    i_den,
    output logic [tdc_pkg::MuW-1:0]     o_quo
);
    localparam int N = tdc_pkg::DivSteps;
    localparam int RW = tdc_pkg::NumW + 1;

    logic [RW-1:0]              r_rem [1:N];
    logic [N-1:0]               r_num [1:N];
    logic [tdc_pkg::NumW-1:0]   r_den [1:N];
    logic                       r_sat [1:N];
    logic [tdc_pkg::MuW:0]      r_q   [1:N];

    for (genvar s = 0; s < N; s++) begin : g_step
        logic [RW-1:0]            w_rem;
        logic [N-1:0]             w_num;
        logic [tdc_pkg::NumW-1:0] w_den;
        logic                     w_sat;
        logic [tdc_pkg::MuW:0]    w_q;
        logic [RW-1:0]            n_sh;
        logic [RW-1:0]            n_rem;
        logic [tdc_pkg::MuW:0]    n_q;
        logic                     n_ge;
        // first stage takes the inputs, later ones the previous stage
        if (s == 0) begin : g_src
            assign w_rem = '0;
            assign w_num = {i_num, 32'd0};
            assign w_den = i_den;
            assign w_sat = 1'b0;
            assign w_q   = '0;
        end else begin : g_src
            assign w_rem = r_rem[s];
            assign w_num = r_num[s];
            assign w_den = r_den[s];
            assign w_sat = r_sat[s];
            assign w_q   = r_q[s];
        end
        always_comb begin
            n_sh  = {w_rem[RW-2:0], w_num[N-1]};
            n_ge  = n_sh >= {1'b0, w_den};
            n_rem = n_ge ? n_sh - {1'b0, w_den} : n_sh;
            n_q   = {w_q[tdc_pkg::MuW-1:0], n_ge};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_num[s+1] <= {w_num[N-2:0], 1'b0};
                r_den[s+1] <= w_den;
                r_q[s+1]   <= n_q;
                r_sat[s+1] <= w_sat | w_q[tdc_pkg::MuW] | n_q[tdc_pkg::MuW];
            end
        end
    end

    assign o_quo = r_sat[N] ? '1 : r_q[N][tdc_pkg::MuW-1:0];
endmodule

>>> design/tdc_sqrt.sv
// Pipelined floor square root of a 116-bit value, one result bit per stage
`timescale 1ns / 1ps
module tdc_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [2*tdc_pkg::MuW-1:0]   i_val,
    output logic [tdc_pkg::MuW-1:0]     o_root
);
    localparam int N  = tdc_pkg::MuW;
    localparam int XW = 2 * tdc_pkg::MuW;
    localparam int RW = tdc_pkg::MuW + 2;

    logic [XW-1:0] r_x   [1:N];
    logic [RW-1:0] r_rem [1:N];
    logic [N-1:0]  r_r   [1:N];

    // Shift-subtract: bring down two radicand bits, try 4*root + 1.
    for (genvar s = 0; s < N; s++) begin : g_bit
        logic [XW-1:0] w_x;
        logic [RW-1:0] w_rem;
        logic [N-1:0]  w_r;
        logic [RW-1:0] n_sh;
        logic [RW-1:0] n_trial;
        logic          n_ge;
        if (s == 0) begin : g_src
            assign w_x   = i_val;
            assign w_rem = '0;
            assign w_r   = '0;
        end else begin : g_src
            assign w_x   = r_x[s];
            assign w_rem = r_rem[s];
            assign w_r   = r_r[s];
        end
        always_comb begin
            n_sh    = {w_rem[RW-3:0], w_x[XW-1:XW-2]};
            n_trial = {w_r, 2'b01};
            n_ge    = n_sh >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s+1]   <= {w_x[XW-3:0], 2'b00};
                r_rem[s+1] <= n_ge ? n_sh - n_trial : n_sh;
                r_r[s+1]   <= {w_r[N-2:0], n_ge};
            end
        end
    end

    assign o_root = r_r[N];
endmodule

>>> bench/tb_triangle_distortion_color.sv
// Testbench: random and directed face colouring checked against a scoreboard predictor
`timescale 1ns / 1ps
module tb_triangle_distortion_color;
    import tdc_pkg::*;

    localparam int  CycleLimit = 600000;
    localparam int  DrainWait  = 300;  // comfortably past the full pipeline depth
    localparam logic [63:0] MuCap  = (64'd1 << 58) - 64'd1;
    localparam logic [63:0] UnitQ32 = 64'd1 << 32;
    localparam logic [63:0] UnitQ48 = 64'd1 << 48;

    // One input request as the sender sees it.
    typedef struct {
        t_op          op;
        logic [11:0]  slot;
        t_vertex      vtx;
        logic [11:0]  ca;
        logic [11:0]  cb;
        logic [11:0]  cc;
    } t_request;

    // Scoreboard: mirrors the vertex stores and the gain, and queues colours.
    class color_scoreboard;
        t_vertex     vstore [VertexCount];
        logic [15:0] gain;
        t_color      pending [$];
        int          errors;

        function new();
            gain   = 16'd32768;
            errors = 0;
        endfunction

        function logic [15:0] shade(logic [63:0] t);
            logic [63:0] p;
            logic [63:0] c;
            if (gain == 16'd0) return 16'hFFFF;
            if (t >= UnitQ48) return 16'd0;
            p = t * {48'd0, gain};
            if (p >= UnitQ48) return 16'd0;
            c = (UnitQ48 - p) >> 32;
            return (c > 64'd65535) ? 16'hFFFF : c[15:0];
        endfunction

        function logic [63:0] ratio_q32(logic [129:0] n, logic [129:0] d);
            logic [199:0] q;
            q = ({70'd0, n} << 32) / {70'd0, d};
            return (q > {136'd0, MuCap}) ? MuCap : q[63:0];
        endfunction

        function t_color shade_face(logic [11:0] ia, logic [11:0] ib, logic [11:0] ic);
            t_vertex a, b, c;
            longint e1x, e1y, e1z, e2x, e2y, e2z, f1u, f1v, f2u, f2v;
            logic signed [129:0] g00, g11, g01, h00, h11, h01;
            logic signed [129:0] det_g, det_h, num, disc;
            logic [129:0] cand;
            logic [63:0] tr, dt, root, mu_hi, mu_lo, red_t, blue_t, green_t;
            t_color r;
            a = vstore[ia];
            b = vstore[ib];
            c = vstore[ic];
            e1x = longint'(b.x) - longint'(a.x);
            e1y = longint'(b.y) - longint'(a.y);
            e1z = longint'(b.z) - longint'(a.z);
            e2x = longint'(c.x) - longint'(a.x);
            e2y = longint'(c.y) - longint'(a.y);
            e2z = longint'(c.z) - longint'(a.z);
            f1u = longint'(b.u) - longint'(a.u);
            f1v = longint'(b.v) - longint'(a.v);
            f2u = longint'(c.u) - longint'(a.u);
            f2v = longint'(c.v) - longint'(a.v);
            g00 = e1x * e1x + e1y * e1y + e1z * e1z;
            g11 = e2x * e2x + e2y * e2y + e2z * e2z;
            g01 = e1x * e2x + e1y * e2y + e1z * e2z;
            h00 = f1u * f1u + f1v * f1v;
            h11 = f2u * f2u + f2v * f2v;
            h01 = f1u * f2u + f1v * f2v;
            det_g = g00 * g11 - g01 * g01;
            if (det_g == 0) begin
                r.red = 16'hFFFF;
                r.green = 16'hFFFF;
                r.blue = 16'hFFFF;
                r.degenerate = 1'b1;
                return r;
            end
            det_h = h00 * h11 - h01 * h01;
            num = g11 * h00 + g00 * h11 - 2 * g01 * h01;
            if (num < 0) num = 0;
            tr = ratio_q32(num, det_g);
            dt = ratio_q32(det_h, det_g);
            disc = $signed({66'd0, tr}) * $signed({66'd0, tr})
                 - ($signed({66'd0, dt}) <<< 34);
            if (disc < 0) disc = 0;
            root = 64'd0;
            for (int i = 63; i >= 0; i--) begin
                cand = {66'd0, root | (64'd1 << i)};
                if (cand * cand <= disc) root = cand[63:0];
            end
            if (root > tr) root = tr;
            mu_hi = (tr + root) >> 1;
            mu_lo = (tr - root) >> 1;
            red_t   = (mu_hi > UnitQ32) ? mu_hi - UnitQ32 : 64'd0;
            blue_t  = (mu_lo < UnitQ32) ? UnitQ32 - mu_lo : 64'd0;
            green_t = (red_t > blue_t) ? red_t : blue_t;
            r.red = shade(red_t);
            r.green = shade(green_t);
            r.blue = shade(blue_t);
            r.degenerate = 1'b0;
            return r;
        endfunction

        function void note_request(t_request q);
            if (q.op == t_OP_VERTEX) vstore[q.slot] = q.vtx;
            else pending.push_back(shade_face(q.ca, q.cb, q.cc));
        endfunction

        function void check_result(t_color got);
            t_color want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d deg=%0b", $time,
                         got.red, got.green, got.blue, got.degenerate);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red)
                $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
            if (got.green !== want.green)
                $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
            if (got.blue !== want.blue)
                $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
            if (got.degenerate !== want.degenerate)
                $display("%0t: degenerate expected %0b actual %0b", $time,
                         want.degenerate, got.degenerate);
            if (got !== want) errors++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = 1'b0;
    logic [11:0] i_vertex_index = '0;
    logic signed [23:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [23:0] i_tex_u = '0, i_tex_v = '0;
    logic [11:0] i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [15:0] o_face_red, o_face_green, o_face_blue;
    logic        o_degenerate;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    color_scoreboard board = new();
    logic [11:0]     written [$];    // slots that faces may name
    bit              written_map [VertexCount];
    int              cycle_count = 0;
    bit              rx_enable = 1'b0;

    always #5 i_clk = ~i_clk;

    triangle_distortion_color u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_vertex_index (i_vertex_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_tex_u        (i_tex_u),
        .i_tex_v        (i_tex_v),
        .i_corner_a     (i_corner_a),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_face_red     (o_face_red),
        .o_face_green   (o_face_green),
        .o_face_blue    (o_face_blue),
        .o_degenerate   (o_degenerate),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // Abort on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Pick a gap length: mostly none or short, now and then long.
    function int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 96) return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    // Result side: stall in random bursts, check every accepted result.
    initial begin
        int     hold;
        t_color got;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (!rx_enable) begin
                i_stall = 1'b1;
            end else if (hold > 0) begin
                i_stall = 1'b1;
                hold--;
            end else begin
                hold = pick_gap();
                i_stall = (hold > 0);
                if (hold > 0) hold--;
            end
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got.red = o_face_red;
                got.green = o_face_green;
                got.blue = o_face_blue;
                got.degenerate = o_degenerate;
                board.check_result(got);
            end
        end
    end

    // Drive one request and hold it until the block takes it.
    task automatic send_request(t_request q);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_operation = q.op;
        i_vertex_index = q.slot;
        i_pos_x = q.vtx.x;
        i_pos_y = q.vtx.y;
        i_pos_z = q.vtx.z;
        i_tex_u = q.vtx.u;
        i_tex_v = q.vtx.v;
        i_corner_a = q.ca;
        i_corner_b = q.cb;
        i_corner_c = q.cc;
        do @(posedge i_clk); while (o_stall);
        board.note_request(q);
        if (q.op == t_OP_VERTEX && !written_map[q.slot]) begin
            written_map[q.slot] = 1'b1;
            written.push_back(q.slot);
        end
    endtask

    task automatic send_idle(int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_operation = 1'($urandom_range(0, 1));   // junk payload while idle
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic put_vertex(logic [11:0] slot, logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [23:0] z, logic signed [23:0] u,
                              logic signed [23:0] v);
        t_request q;
        q = '{op: t_OP_VERTEX, slot: slot, vtx: '{x, y, z, u, v},
              ca: 12'($urandom), cb: 12'($urandom), cc: 12'($urandom)};
        send_request(q);
    endtask

    task automatic put_face(logic [11:0] a, logic [11:0] b, logic [11:0] c);
        t_request q;
        q = '{op: t_OP_FACE, slot: 12'($urandom),
              vtx: '{24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom)},
              ca: a, cb: b, cc: c};
        send_request(q);
    endtask

    // Hold the sender until every face is out and the pipe has drained.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [15:0] g);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = g;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.gain = g;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data = 16'($urandom);
    endtask

    // Random coordinate: random magnitude scale so small and full-range values both occur.
    function logic signed [23:0] rand_coord();
        logic signed [23:0] w;
        w = 24'($urandom);
        return w >>> $urandom_range(0, 22);
    endfunction

    task automatic random_vertex();
        logic signed [23:0] x, y, z, u, v;
        int s;
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
        case ($urandom_range(0, 3))
            0: begin
                u = rand_coord();
                v = rand_coord();
            end
            1: begin
                // parameterization close to the surface: mild distortion
                s = $urandom_range(0, 2);
                u = x >>> s;
                v = y >>> s;
            end
            2: begin
                u = z;
                v = x;
            end
            default: begin
                u = x;
                v = y;
            end
        endcase
        put_vertex(12'($urandom), x, y, z, u, v);
    endtask

    task automatic random_face();
        logic [11:0] a, b, c;
        a = written[$urandom_range(0, written.size() - 1)];
        b = written[$urandom_range(0, written.size() - 1)];
        c = written[$urandom_range(0, written.size() - 1)];
        // repeated corners now and then give degenerate faces
        if ($urandom_range(0, 19) == 0) b = a;
        put_face(a, b, c);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (written.size() < 3 || $urandom_range(0, 99) < 35) random_vertex();
            else random_face();
            send_idle(pick_gap());
        end
    endtask

    localparam logic signed [23:0] One  = 24'sd65536;
    localparam logic signed [23:0] CMax = 24'sh7FFFFF;
    localparam logic signed [23:0] CMin = -24'sh800000;

    initial begin
        for (int i = 0; i < VertexCount; i++) written_map[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        rx_enable = 1'b1;

        // Directed: identity mapping, stretch, flat uv, degenerate and extreme faces.
        write_gain(16'd32768);
        put_vertex(12'd1, 0, 0, 0, 0, 0);
        put_vertex(12'd2, One, 0, 0, One, 0);
        put_vertex(12'd3, 0, One, 0, 0, One);
        put_face(12'd1, 12'd2, 12'd3);
        put_vertex(12'd4, 0, 0, 0, 0, 0);
        put_vertex(12'd5, One, 0, 0, 24'(2 * One), 0);
        put_vertex(12'd6, 0, 0, One, 0, 24'(3 * One));
        put_face(12'd4, 12'd5, 12'd6);
        put_vertex(12'd7, 24'(2 * One), 0, 0, 5, 5);
        put_face(12'd1, 12'd1, 12'd2);
        put_face(12'd1, 12'd2, 12'd7);
        put_vertex(12'd8, 0, 0, One, 7, 7);
        put_vertex(12'd9, One, One, One, 7, 7);
        put_face(12'd8, 12'd9, 12'd2);
        put_vertex(12'd0, CMin, CMin, CMin, CMin, CMin);
        put_vertex(12'd4095, CMax, CMax, CMax, CMax, CMax);
        put_vertex(12'd2048, CMax, CMin, CMax, CMin, CMax);
        put_face(12'd0, 12'd4095, 12'd2048);
        put_face(12'd2048, 12'd0, 12'd4095);
        put_face(12'd0, 12'd4095, 12'd4095);
        put_vertex(12'd10, One, 0, 0, 24'(One / 4), 0);
        put_vertex(12'd11, 0, One, 0, 0, 24'(One / 4));
        put_face(12'd1, 12'd10, 12'd11);

        // Gain extremes on the same faces.
        write_gain(16'd0);
        put_face(12'd4, 12'd5, 12'd6);
        put_face(12'd1, 12'd10, 12'd11);
        write_gain(16'hFFFF);
        put_face(12'd4, 12'd5, 12'd6);
        put_face(12'd1, 12'd10, 12'd11);
        put_face(12'd0, 12'd4095, 12'd2048);

        // Random phases over several gain settings.
        write_gain(16'd1);
        random_phase(250);
        write_gain(16'hFFFF);
        random_phase(300);
        write_gain(16'd0);
        random_phase(150);
        write_gain(16'd32768);
        random_phase(350);
        write_gain(16'($urandom));
        random_phase(250);
        write_gain(16'($urandom_range(1, 4096)));
        random_phase(250);

        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
design/tdc_pkg.sv
design/tdc_vstore.sv
design/tdc_divider.sv
design/tdc_sqrt.sv
design/triangle_distortion_color.sv
bench/tb_triangle_distortion_color.sv
